[design/fsp_pkg.sv]
package fsp_pkg;

    localparam int MAX_COLS = 16;
    localparam int CNT_W    = 16;
    localparam int COL_W    = 4;
    localparam int CTOT_W   = 5;
    localparam int NCMD     = 3;
    localparam int NCMD_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] PH_SKIP  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [2:0] K_BYTE  = 3'd0;
    localparam logic [2:0] K_FEND  = 3'd1;
    localparam logic [2:0] K_REND  = 3'd2;
    localparam logic [2:0] K_EMPTY = 3'd3;
    localparam logic [2:0] K_FIN   = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SKIPEND = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_NOSEP   = 3'd3;
    localparam logic [2:0] ST_TOOMANY = 3'd4;

    localparam logic [2:0] CFG_SEP_MASK = 3'd0;
    localparam logic [2:0] CFG_COLLAPSE = 3'd1;
    localparam logic [2:0] CFG_HEADER   = 3'd2;
    localparam logic [2:0] CFG_SKIP_EMP = 3'd3;
    localparam logic [2:0] CFG_SKIP_LN  = 3'd4;
    localparam logic [2:0] CFG_MAX_LN   = 3'd5;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // One command covers a run of results that differ only in column.
    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        byt;
        logic [COL_W-1:0]  col_lo;
        logic [COL_W-1:0]  col_hi;
        logic [CNT_W-1:0]  row;
        logic              hdr;
        logic              rerr;
        logic [2:0]        status;
        logic [CTOT_W-1:0] ctot;
        logic              anyerr;
    } t_cmd;

    typedef struct packed {
        t_cmd [NCMD-1:0]   cmd;
        logic [NCMD_W-1:0] n;
    } t_bundle;

endpackage

[design/fsp_in_if.sv]
interface fsp_in_if;
    import fsp_pkg::*;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;
    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

[design/fsp_out_if.sv]
interface fsp_out_if;
    import fsp_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        out_kind;
    logic [7:0]        out_byte;
    logic [COL_W-1:0]  column;
    logic [CNT_W-1:0]  row_index;
    logic              is_header;
    logic              row_error;
    logic [2:0]        status;
    logic [CTOT_W-1:0] column_count;
    logic              any_error;
    logic              last;
    modport source (output valid, output out_kind, output out_byte, output column,
                    output row_index, output is_header, output row_error, output status,
                    output column_count, output any_error, output last, input ready);
    modport sink (input valid, input out_kind, input out_byte, input column,
                  input row_index, input is_header, input row_error, input status,
                  input column_count, input any_error, input last, output ready);
endinterface

[design/fsp_front.sv]
module fsp_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    fsp_in_if.sink                          i_in,
    input  logic                            i_full,
    output logic                            o_push,
    output fsp_pkg::t_bundle                o_bun
);
    import fsp_pkg::*;

    localparam logic [CTOT_W-1:0] MAXC = CTOT_W'(MAX_COLS);

    function automatic t_cmd f_cmd(input logic [2:0] kind, input logic [7:0] byt,
                                   input logic [COL_W-1:0] lo, input logic [COL_W-1:0] hi,
                                   input logic rerr, input logic [1:0] ph, input logic hh,
                                   input logic [CNT_W-1:0] rows, input logic [2:0] fs,
                                   input logic [CTOT_W-1:0] ct, input logic st);
        t_cmd c;
        logic hdr;
        hdr      = (kind != K_FIN) && (ph == PH_FIRST) && hh;
        c.kind   = kind;
        c.byt    = byt;
        c.col_lo = lo;
        c.col_hi = hi;
        c.row    = hdr ? '0 : rows;
        c.hdr    = hdr;
        c.rerr   = rerr;
        c.status = fs;
        c.ctot   = ct;
        c.anyerr = st;
        return c;
    endfunction

    function automatic logic f_is_sep(input logic [7:0] b, input logic [2:0] m);
        return (b == CH_TAB && m[0]) || (b == CH_COMMA && m[1]) || (b == CH_SPACE && m[2]);
    endfunction

    logic [2:0]        r_sep_mask;
    logic              r_collapse, r_has_hdr, r_skip_emp;
    logic [15:0]       r_skip_ln, r_max_ln;

    logic              r_started, n_started;
    logic [1:0]        r_phase, n_phase;
    logic [15:0]       r_skip_left, n_skip_left;
    logic [15:0]       r_lines_left, n_lines_left;
    logic [CTOT_W-1:0] r_ctot, n_ctot;
    logic [COL_W-1:0]  r_cur, n_cur;
    logic [7:0]        r_prev, n_prev;
    logic              r_pcr, n_pcr;
    logic              r_nonempty, n_nonempty;
    logic              r_trunc, n_trunc;
    logic              r_lerr, n_lerr;
    logic              r_sticky, n_sticky;
    logic [CNT_W-1:0]  r_rows, n_rows;
    logic [2:0]        r_fatal, n_fatal;

    logic              acc;
    t_bundle           bun;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && i_in.ready;
    assign o_push     = acc && (bun.n != '0);
    assign o_bun      = bun;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_mask <= 3'd2;
            r_collapse <= 1'b0;
            r_has_hdr  <= 1'b0;
            r_skip_emp <= 1'b0;
            r_skip_ln  <= '0;
            r_max_ln   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEP_MASK: r_sep_mask <= i_cfg_data[2:0];
                CFG_COLLAPSE: r_collapse <= i_cfg_data[0];
                CFG_HEADER:   r_has_hdr  <= i_cfg_data[0];
                CFG_SKIP_EMP: r_skip_emp <= i_cfg_data[0];
                CFG_SKIP_LN:  r_skip_ln  <= i_cfg_data;
                CFG_MAX_LN:   r_max_ln   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [1:0]  p0;
        logic [2:0]  fb;
        logic        act;
        logic        do_end;
        logic [7:0]  cb;
        logic        en;
        logic [NCMD_W-1:0] nc;
        logic [7:0]  b;
        b = i_in.data_byte;
        n_started = r_started;     n_phase = r_phase;       n_skip_left = r_skip_left;
        n_lines_left = r_lines_left; n_ctot = r_ctot;       n_cur = r_cur;
        n_prev = r_prev;           n_pcr = r_pcr;           n_nonempty = r_nonempty;
        n_trunc = r_trunc;         n_lerr = r_lerr;         n_sticky = r_sticky;
        n_rows = r_rows;           n_fatal = r_fatal;
        bun = '0;
        nc  = '0;
        if (!n_started) begin
            n_started    = 1'b1;
            n_skip_left  = r_skip_ln;
            n_lines_left = r_max_ln;
            n_phase      = (r_skip_ln != '0) ? PH_SKIP : PH_FIRST;
        end
        p0  = n_phase;
        fb  = n_fatal;
        act = !i_in.req_type && (p0 == PH_FIRST || p0 == PH_DATA);
        do_end = (i_in.req_type && (p0 == PH_FIRST ||
                  (p0 == PH_DATA && (n_nonempty || n_pcr)))) || (act && b == CH_LF);

        // Content: a held-back CR that turned out to be data, then the byte itself.
        for (int i = 0; i < 2; i++) begin
            cb = (i == 0) ? CH_CR : b;
            en = (i == 0) ? (act && n_pcr && b != CH_LF)
                          : (act && b != CH_LF && b != CH_CR);
            if (i == 0 && act) n_pcr = 1'b0;
            if (en) begin
                n_nonempty = 1'b1;
                if (!n_trunc && !(r_collapse && n_prev != 8'd0 && cb == n_prev)) begin
                    if (f_is_sep(cb, r_sep_mask)) begin
                        n_prev = cb;
                        if (n_phase == PH_FIRST && ({1'b0, n_cur} + 5'd1) >= MAXC) begin
                            n_fatal  = ST_TOOMANY;
                            n_sticky = 1'b1;
                            n_phase  = PH_DONE;
                        end else if (n_phase != PH_FIRST &&
                                     ({1'b0, n_cur} + 5'd1) >= n_ctot) begin
                            n_trunc = 1'b1;
                            n_lerr  = 1'b1;
                        end else begin
                            bun.cmd[nc] = f_cmd(K_FEND, 8'd0, n_cur, n_cur, 1'b0, n_phase,
                                                r_has_hdr, n_rows, n_fatal, n_ctot, n_sticky);
                            nc = nc + 1'b1;
                            n_cur = n_cur + 1'b1;
                        end
                    end else begin
                        n_prev = 8'd0;
                        bun.cmd[nc] = f_cmd(K_BYTE, cb, n_cur, n_cur, 1'b0, n_phase,
                                            r_has_hdr, n_rows, n_fatal, n_ctot, n_sticky);
                        nc = nc + 1'b1;
                    end
                end
            end
        end

        if (do_end) begin
            n_pcr = 1'b0;
            if (n_phase == PH_FIRST) begin
                if (!n_nonempty || n_cur == '0) begin
                    n_fatal  = !n_nonempty ? ST_EMPTY : ST_NOSEP;
                    n_sticky = 1'b1;
                    n_phase  = PH_DONE;
                end else begin
                    n_ctot = {1'b0, n_cur} + 5'd1;
                    bun.cmd[nc] = f_cmd(K_FEND, 8'd0, n_cur, n_cur, 1'b0, n_phase,
                                        r_has_hdr, n_rows, n_fatal, n_ctot, n_sticky);
                    nc = nc + 1'b1;
                    bun.cmd[nc] = f_cmd(K_REND, 8'd0, '0, '0, 1'b0, n_phase,
                                        r_has_hdr, n_rows, n_fatal, n_ctot, n_sticky);
                    nc = nc + 1'b1;
                    n_phase = PH_DATA;
                    if (!r_has_hdr) begin
                        if (n_rows != '1) n_rows = n_rows + 1'b1;
                        if (n_lines_left != '0) begin
                            n_lines_left = n_lines_left - 1'b1;
                            if (n_lines_left == '0) n_phase = PH_DONE;
                        end
                    end
                end
            end else if (n_phase == PH_DATA) begin
                if (!n_nonempty) begin
                    if (!r_skip_emp) begin
                        n_sticky = 1'b1;
                        bun.cmd[nc] = f_cmd(K_EMPTY, 8'd0, '0, '0, 1'b1, n_phase,
                                            r_has_hdr, n_rows, n_fatal, n_ctot, n_sticky);
                        nc = nc + 1'b1;
                    end
                end else begin
                    if (({1'b0, n_cur} + 5'd1) < n_ctot) n_lerr = 1'b1;
                    // Missing columns are padded with empty fields in one run.
                    bun.cmd[nc] = f_cmd(K_FEND, 8'd0, n_cur, COL_W'(n_ctot - 5'd1), 1'b0,
                                        n_phase, r_has_hdr, n_rows, n_fatal, n_ctot,
                                        n_sticky);
                    nc = nc + 1'b1;
                    if (n_lerr) n_sticky = 1'b1;
                    bun.cmd[nc] = f_cmd(K_REND, 8'd0, '0, '0, n_lerr, n_phase,
                                        r_has_hdr, n_rows, n_fatal, n_ctot, n_sticky);
                    nc = nc + 1'b1;
                    if (n_rows != '1) n_rows = n_rows + 1'b1;
                end
                if (n_lines_left != '0) begin
                    n_lines_left = n_lines_left - 1'b1;
                    if (n_lines_left == '0) n_phase = PH_DONE;
                end
            end
            n_cur = '0; n_prev = 8'd0; n_nonempty = 1'b0; n_trunc = 1'b0; n_lerr = 1'b0;
        end

        if (i_in.req_type) begin
            if (p0 == PH_SKIP) begin
                n_fatal  = ST_SKIPEND;
                n_sticky = 1'b1;
            end
            n_phase = PH_DONE;
            bun.cmd[nc] = f_cmd(K_FIN, 8'd0, '0, '0, 1'b0, n_phase, r_has_hdr, n_rows,
                                n_fatal, n_ctot, n_sticky);
            nc = nc + 1'b1;
        end else if (p0 == PH_SKIP) begin
            if (b == CH_LF) begin
                n_skip_left = n_skip_left - 1'b1;
                if (n_skip_left == '0) n_phase = PH_FIRST;
            end
        end else if (act) begin
            if (b == CH_CR) n_pcr = 1'b1;
            if (n_fatal != fb) begin
                bun.cmd[nc] = f_cmd(K_FIN, 8'd0, '0, '0, 1'b0, n_phase, r_has_hdr, n_rows,
                                    n_fatal, n_ctot, n_sticky);
                nc = nc + 1'b1;
            end
        end
        bun.n = nc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;  r_phase <= PH_SKIP;  r_skip_left <= '0;
            r_lines_left <= '0; r_ctot <= '0;        r_cur <= '0;
            r_prev <= '0;       r_pcr <= 1'b0;       r_nonempty <= 1'b0;
            r_trunc <= 1'b0;    r_lerr <= 1'b0;      r_sticky <= 1'b0;
            r_rows <= '0;       r_fatal <= ST_OK;
        end else if (acc) begin
            r_started <= n_started;   r_phase <= n_phase;   r_skip_left <= n_skip_left;
            r_lines_left <= n_lines_left; r_ctot <= n_ctot; r_cur <= n_cur;
            r_prev <= n_prev;         r_pcr <= n_pcr;       r_nonempty <= n_nonempty;
            r_trunc <= n_trunc;       r_lerr <= n_lerr;     r_sticky <= n_sticky;
            r_rows <= n_rows;         r_fatal <= n_fatal;
        end
    end

endmodule

[design/fsp_queue.sv]
module fsp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fsp_pkg::t_bundle i_bun,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output fsp_pkg::t_bundle o_bun
);
    import fsp_pkg::*;

    t_bundle    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_bun   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bun;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

[design/fsp_back.sv]
module fsp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  fsp_pkg::t_bundle i_bun,
    output logic             o_pop,
    fsp_out_if.source        o_out
);
    import fsp_pkg::*;

    logic              r_busy;
    t_bundle           r_bun;
    logic [NCMD_W-1:0] r_ci;
    logic [COL_W-1:0]  r_col;
    logic              r_oval;
    t_cmd              r_ocmd;
    logic [COL_W-1:0]  r_ocol;
    logic              r_olast;

    t_cmd              cur;
    logic              adv, end_cmd, end_bun, load;

    assign cur     = r_bun.cmd[r_ci];
    assign adv     = r_busy && (!r_oval || o_out.ready);
    assign end_cmd = (r_col == cur.col_hi);
    assign end_bun = end_cmd && (r_ci == r_bun.n - 1'b1);
    assign load    = i_valid && (!r_busy || (adv && end_bun));
    assign o_pop   = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            if (load)             r_busy <= 1'b1;
            else if (adv && end_bun) r_busy <= 1'b0;
            if (adv)               r_oval <= 1'b1;
            else if (o_out.ready)  r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bun <= i_bun;
            r_ci  <= '0;
            r_col <= i_bun.cmd[0].col_lo;
        end else if (adv && !end_bun) begin
            if (end_cmd) begin
                r_ci  <= r_ci + 1'b1;
                r_col <= r_bun.cmd[r_ci + 1'b1].col_lo;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
        if (adv) begin
            r_ocmd  <= cur;
            r_ocol  <= r_col;
            r_olast <= end_bun;
        end
    end

    assign o_out.valid        = r_oval;
    assign o_out.out_kind     = r_ocmd.kind;
    assign o_out.out_byte     = r_ocmd.byt;
    assign o_out.column       = r_ocol;
    assign o_out.row_index    = r_ocmd.row;
    assign o_out.is_header    = r_ocmd.hdr;
    assign o_out.row_error    = r_ocmd.rerr;
    assign o_out.status       = r_ocmd.status;
    assign o_out.column_count = r_ocmd.ctot;
    assign o_out.any_error    = r_ocmd.anyerr;
    assign o_out.last         = r_olast;

`ifndef ASSERT_OFF
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !r_oval && !r_busy)
        else $error("output valid or busy after reset");
    a_ci_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_ci < r_bun.n))
        else $error("command index beyond bundle");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_col <= cur.col_hi))
        else $error("column past end of run");
    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && r_ocmd.kind == K_FIN) |-> r_olast)
        else $error("finished result not marked last");
`endif

endmodule

[design/delimited_text_field_splitter.sv]
// Byte-stream field splitter: one request carries a text byte or an end-of-input
// mark, and each request yields zero to eighteen results (bytes, field ends, row
// ends, empty-line events, finished). A front stage classifies one byte per cycle
// and packs its results into up to three commands, a two-entry queue holds them,
// and a back stage sends one result per cycle while the output is ready. Requests
// are taken every cycle while the queue has room; the back stage sets the sustained
// rate, so a line end that pads missing columns stalls the front once the queue is
// full. Configuration must be written only while idle; the block does not enforce
// this. skip_lines and max_lines are sampled at the first request after reset.
module delimited_text_field_splitter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    fsp_in_if.sink                          i_in,
    fsp_out_if.source                       o_out
);
    import fsp_pkg::*;

    logic    push, full, pop, qval;
    t_bundle fbun, qbun;

    fsp_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in, .i_full(full), .o_push(push), .o_bun(fbun)
    );

    fsp_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_bun(fbun), .o_full(full),
        .i_pop(pop), .o_valid(qval), .o_bun(qbun)
    );

    fsp_back u_back (
        .i_clk, .i_rst_n, .i_valid(qval), .i_bun(qbun), .o_pop(pop), .o_out
    );

endmodule
